// ===== rtl/stl_pkg.sv =====
// shared types and constants for the script text lexer
package stl_pkg;

    localparam int QUEUE_DEPTH = 2;

    // results that one input byte causes, in output order:
    // end mark, token byte, end mark
    typedef struct packed {
        logic       lead_end;
        logic       byte_en;
        logic [7:0] byte_val;
        logic       trail_end;
    } stl_bundle_t;

endpackage

// ===== rtl/script_text_lexer.sv =====
// top level of the byte-serial script text lexer
//
// takes one script text byte per request and emits token bytes and
// token-end marks. the front end classifies each byte against the current
// lexer mode (empty, bare word, quoted string, comment) and turns it into a
// bundle of zero to three results; the bundles wait in a short fifo and the
// back end hands them out one result per request from its output register.
// a byte is taken every cycle as long as the fifo has room, so ordinary
// text runs at one byte per cycle; a delimiter that closes an open word
// yields three results, handed out one per request, which the fifo
// absorbs until it fills (QUEUE_DEPTH bundles). bytes that cause no result
// (blanks outside a word, comment text) are consumed without touching the
// fifo. a result passes the fifo and then the back end output register.
module script_text_lexer
#(
    parameter int QUEUE_DEPTH = stl_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] end_of_stream
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] token_byte
    output logic       m_tuser,   // [0] kind
    output logic       m_tlast    // last result of this input byte
);
    import stl_pkg::*;

    stl_bundle_t front_bundle;
    stl_bundle_t q_data;
    logic        front_push;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;
    logic        in_accept;

    // take a byte whenever the fifo can hold its bundle
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    stl_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .data_byte     (s_tdata),
        .end_of_stream (s_tuser),
        .push          (front_push),
        .bundle        (front_bundle)
    );

    stl_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_bundle),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // serializer drives the result stream straight from its registers
    stl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_data),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

endmodule

// ===== rtl/stl_front.sv =====
// front end: byte classification and lexer mode tracking
module stl_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_stream,
    output logic                push,
    output stl_pkg::stl_bundle_t bundle
);
    import stl_pkg::*;

    localparam logic [1:0] MODE_EMPTY   = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       word_open;
    logic       is_blank;

    assign word_open = (mode_reg == MODE_WORD);
    // newline falls inside the blank range
    assign is_blank  = data_byte inside {[8'h09:8'h0D], 8'h20};

    always_comb
    begin
        mode_next        = mode_reg;
        bundle.lead_end  = 1'b0;
        bundle.byte_en   = 1'b0;
        bundle.byte_val  = data_byte;
        bundle.trail_end = 1'b0;
        if (end_of_stream)
        begin
            bundle.lead_end = (mode_reg == MODE_WORD) || (mode_reg == MODE_STRING);
            mode_next       = MODE_EMPTY;
        end
        else
        begin
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (data_byte == CH_NEWLINE)
                    begin
                        mode_next = MODE_EMPTY;
                    end
                end
                MODE_STRING:
                begin
                    if (data_byte == CH_NEWLINE)
                    begin
                        bundle.lead_end = 1'b1;
                        mode_next       = MODE_EMPTY;
                    end
                    else if (data_byte == CH_QUOTE)
                    begin
                        bundle.byte_en   = 1'b1;
                        bundle.trail_end = 1'b1;
                        mode_next        = MODE_EMPTY;
                    end
                    else
                    begin
                        bundle.byte_en = 1'b1;
                    end
                end
                default:
                begin
                    if (data_byte == CH_HASH)
                    begin
                        bundle.lead_end = word_open;
                        mode_next       = MODE_COMMENT;
                    end
                    else if (is_blank)
                    begin
                        bundle.lead_end = word_open;
                        mode_next       = MODE_EMPTY;
                    end
                    else if (data_byte == CH_QUOTE && !word_open)
                    begin
                        bundle.byte_en = 1'b1;
                        mode_next      = MODE_STRING;
                    end
                    else if (data_byte inside {CH_LBRACE, CH_RBRACE, CH_EQUALS})
                    begin
                        bundle.lead_end  = word_open;
                        bundle.byte_en   = 1'b1;
                        bundle.trail_end = 1'b1;
                        mode_next        = MODE_EMPTY;
                    end
                    else
                    begin
                        bundle.byte_en = 1'b1;
                        mode_next      = MODE_WORD;
                    end
                end
            endcase
        end
    end

    assign push = accept && (bundle.lead_end || bundle.byte_en || bundle.trail_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EMPTY;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== rtl/stl_queue.sv =====
// short fifo of result bundles between front and back
module stl_queue
#(
    parameter int DEPTH = stl_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stl_pkg::stl_bundle_t push_data,
    input  logic                 pop,
    output stl_pkg::stl_bundle_t pop_data,
    output logic                 not_empty,
    output logic                 full
);
    import stl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    stl_bundle_t   store [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

// ===== rtl/stl_back.sv =====
// back end: serializes a bundle into single result requests
module stl_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stl_pkg::stl_bundle_t q_data,
    input  logic                 q_not_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_kind,
    output logic [7:0]           out_byte,
    output logic                 out_last
);
    import stl_pkg::*;

    stl_bundle_t cur_reg;
    stl_bundle_t cur_next;
    logic        fire;

    assign out_valid = cur_reg.lead_end || cur_reg.byte_en || cur_reg.trail_end;
    assign out_kind  = cur_reg.lead_end || !cur_reg.byte_en;
    assign out_byte  = out_kind ? 8'h00 : cur_reg.byte_val;
    // last when exactly one pending result remains
    assign out_last  = ({1'b0, cur_reg.lead_end} + {1'b0, cur_reg.byte_en}
                        + {1'b0, cur_reg.trail_end}) == 2'd1;
    assign fire      = out_valid && out_ready;
    assign q_pop     = q_not_empty && (!out_valid || (fire && out_last));

    always_comb
    begin
        cur_next = cur_reg;
        if (q_pop)
        begin
            cur_next = q_data;
        end
        else if (fire)
        begin
            if (cur_reg.lead_end)
            begin
                cur_next.lead_end = 1'b0;
            end
            else if (cur_reg.byte_en)
            begin
                cur_next.byte_en = 1'b0;
            end
            else
            begin
                cur_next.trail_end = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
    end

endmodule

// ===== tb/tb_script_text_lexer.sv =====
// self-checking testbench for the script text lexer: directed and random byte streams
module tb_script_text_lexer;

    timeunit 1ns;
    timeprecision 1ps;

    // result kinds on m_tuser
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // bytes with a meaning of their own to the lexer
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // run ends here no matter what
    localparam int CYCLE_LIMIT = 100000;
    // requests wanted from the random part
    localparam int RANDOM_TARGET = 60;
    // requests wanted from the closing full-rate stretch
    localparam int FULL_RATE_TARGET = 25;

    typedef enum logic [1:0] {
        LEX_EMPTY,
        LEX_WORD,
        LEX_STRING,
        LEX_COMMENT
    } lex_mode_t;

    typedef struct {
        logic       kind;
        logic [7:0] tok;
        logic       last;
    } lex_result_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // predictor state and the results still owed by the block
    lex_mode_t   lex_mode;
    lex_result_t expected_tokens[$];

    int  error_count;
    int  cycle_count;
    int  sent_requests;
    // idling switches for the two sides
    bit  tx_idle_en;
    bit  rx_stall_en;

    script_text_lexer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_tokens.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    function automatic lex_result_t make_result(input logic kind, input logic [7:0] tok);
        lex_result_t r;
        r.kind = kind;
        r.tok  = (kind == KIND_END) ? 8'h00 : tok;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    // advance the lexer by one request and queue the token bytes and end marks it owes
    function automatic int lex_predict(input logic [7:0] c, input logic eos);
        lex_result_t res[3];
        int          n;
        bit          word_open;
        n = 0;
        word_open = (lex_mode == LEX_WORD);
        if (eos)
        begin
            // closes a word or string, data byte is ignored
            if (lex_mode == LEX_WORD || lex_mode == LEX_STRING)
            begin
                res[n] = make_result(KIND_END, 8'h00);
                n++;
            end
            lex_mode = LEX_EMPTY;
        end
        else if (lex_mode == LEX_COMMENT)
        begin
            // everything dropped up to and including the newline
            if (c == CH_NEWLINE)
                lex_mode = LEX_EMPTY;
        end
        else if (lex_mode == LEX_STRING)
        begin
            if (c == CH_NEWLINE)
            begin
                // unterminated string closed by the line end, newline not kept
                res[n] = make_result(KIND_END, 8'h00);
                n++;
                lex_mode = LEX_EMPTY;
            end
            else if (c == CH_QUOTE)
            begin
                res[n] = make_result(KIND_BYTE, c);
                n++;
                res[n] = make_result(KIND_END, 8'h00);
                n++;
                lex_mode = LEX_EMPTY;
            end
            else
            begin
                res[n] = make_result(KIND_BYTE, c);
                n++;
            end
        end
        else if (c == CH_HASH)
        begin
            if (word_open)
            begin
                res[n] = make_result(KIND_END, 8'h00);
                n++;
            end
            lex_mode = LEX_COMMENT;
        end
        else if (is_blank(c))
        begin
            if (word_open)
            begin
                res[n] = make_result(KIND_END, 8'h00);
                n++;
            end
            lex_mode = LEX_EMPTY;
        end
        else if (c == CH_QUOTE && !word_open)
        begin
            res[n] = make_result(KIND_BYTE, c);
            n++;
            lex_mode = LEX_STRING;
        end
        else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_EQUAL)
        begin
            // close the open word, then the delimiter is a token of its own
            if (word_open)
            begin
                res[n] = make_result(KIND_END, 8'h00);
                n++;
            end
            res[n] = make_result(KIND_BYTE, c);
            n++;
            res[n] = make_result(KIND_END, 8'h00);
            n++;
            lex_mode = LEX_EMPTY;
        end
        else
        begin
            // ordinary word byte, including a quote inside a word
            res[n] = make_result(KIND_BYTE, c);
            n++;
            lex_mode = LEX_WORD;
        end
        for (int i = 0; i < n; i++)
        begin
            res[i].last = (i == n - 1);
            expected_tokens = {expected_tokens, res[i]};
        end
        return n;
    endfunction

    // one request on the byte stream, with an occasional idle burst before it
    task automatic send_byte(input logic [7:0] c, input logic eos = 1'b0);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tuser  = eos;
        do
            @(posedge clk);
        while (!s_tready);
        void'(lex_predict(c, eos));
        sent_requests++;
    endtask

    task automatic send_end_of_stream();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold the sender off until every owed result has come out
    task automatic pause_until_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    // receiver side: random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (rx_stall_en && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                m_tready = 1'b1;
        end
    end

    // result checker against the oldest owed result
    always @(posedge clk)
    begin
        lex_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch($sformatf("unexpected result kind=%0b byte=%02h last=%0b",
                                          m_tuser, m_tdata, m_tlast));
            else
            begin
                want = expected_tokens.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0b, want %0b", m_tuser, want.kind));
                if (m_tdata !== want.tok)
                    report_mismatch($sformatf("token byte %02h, want %02h", m_tdata, want.tok));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    // any byte that keeps a bare word going and cannot start a string
    function automatic logic [7:0] pick_word_byte();
        logic [7:0] c;
        do
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(33, 126));
        while (c == CH_HASH || c == CH_QUOTE || c == CH_LBRACE || c == CH_RBRACE
               || c == CH_EQUAL);
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        int sel;
        sel = $urandom_range(0, 5);
        return (sel == 5) ? CH_SPACE : CH_TAB + 8'(sel);
    endfunction

    function automatic logic [7:0] pick_delimiter();
        int sel;
        sel = $urandom_range(0, 2);
        return (sel == 0) ? CH_LBRACE : (sel == 1) ? CH_RBRACE : CH_EQUAL;
    endfunction

    // any byte except the ones that end a string or a comment line
    function automatic logic [7:0] pick_body_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_NEWLINE);
        return c;
    endfunction

    // extremes of the byte range, blanks, and a quote landing inside a word
    task automatic test_words_and_blanks();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_SPACE);
        send_byte(CH_TAB);
        send_byte("w");
        send_byte(CH_QUOTE);
        send_byte(CH_CR);
    endtask

    // lone delimiter and delimiters closing an open word
    task automatic test_delimiters();
        send_byte(CH_LBRACE);
        send_byte("k");
        send_byte(CH_EQUAL);
        send_byte("v");
        send_byte(CH_RBRACE);
    endtask

    // string with specials kept verbatim, then one cut off by the line end
    task automatic test_strings();
        send_byte(CH_QUOTE);
        send_byte(CH_HASH);
        send_byte(CH_SPACE);
        send_byte(CH_LBRACE);
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
        send_byte(CH_NEWLINE);
    endtask

    // hash ends the word, delimiters in the comment are dropped
    task automatic test_comments();
        send_byte("c");
        send_byte(CH_HASH);
        send_byte(CH_RBRACE);
        send_byte(CH_NEWLINE);
    endtask

    // end of stream in every lexer mode
    task automatic test_end_of_stream();
        send_byte("e");
        send_end_of_stream();
        send_end_of_stream();
        send_byte(CH_QUOTE);
        send_end_of_stream();
        send_byte(CH_HASH);
        send_end_of_stream();
        send_byte("z");
        send_end_of_stream();
    endtask

    // one script-like fragment with random content, occasionally plain noise
    task automatic send_fragment();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            len = $urandom_range(1, 5);
            repeat (len) send_byte(pick_word_byte());
        end
        else if (sel < 45)
            send_byte(pick_delimiter());
        else if (sel < 60)
            send_byte(pick_blank());
        else if (sel < 72)
        begin
            send_byte(CH_QUOTE);
            len = $urandom_range(0, 4);
            repeat (len) send_byte(pick_body_byte());
            case ($urandom_range(0, 5))
                0:       send_byte(CH_NEWLINE);
                1:       send_end_of_stream();
                default: send_byte(CH_QUOTE);
            endcase
        end
        else if (sel < 80)
        begin
            send_byte(CH_HASH);
            len = $urandom_range(0, 3);
            repeat (len) send_byte(pick_body_byte());
            send_byte(CH_NEWLINE);
        end
        else if (sel < 84)
            send_end_of_stream();
        else if (sel < 90)
        begin
            // word with a quote in the middle
            send_byte(pick_word_byte());
            send_byte(CH_QUOTE);
            send_byte(pick_word_byte());
        end
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // random script text with idling on both sides and one full drain midway
    task automatic test_random_script();
        int start_count;
        bit drained;
        start_count = sent_requests;
        drained = 1'b0;
        while (sent_requests - start_count < RANDOM_TARGET)
        begin
            send_fragment();
            if (!drained && sent_requests - start_count >= RANDOM_TARGET / 2)
            begin
                pause_until_drained();
                drained = 1'b1;
            end
        end
    endtask

    // closing stretch at full rate, no idling anywhere
    task automatic test_full_rate();
        int start_count;
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        start_count = sent_requests;
        while (sent_requests - start_count < FULL_RATE_TARGET)
            send_fragment();
        send_end_of_stream();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        lex_mode = LEX_EMPTY;
        error_count = 0;
        cycle_count = 0;
        sent_requests = 0;
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_words_and_blanks();
        test_delimiters();
        test_strings();
        test_comments();
        test_end_of_stream();
        test_random_script();
        test_full_rate();

        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        // catch stray results after the last owed one
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/stl_pkg.sv
rtl/stl_front.sv
rtl/stl_queue.sv
rtl/stl_back.sv
rtl/script_text_lexer.sv
tb/tb_script_text_lexer.sv
